### hw/rtl/smqc_pkg.sv
package smqc_pkg;

    // Field widths fixed by the item format
    localparam int unsigned ACTION_W = 2;
    localparam int unsigned CH_W     = 3;
    localparam int unsigned RAW_W    = 10;
    localparam int unsigned VAL_W    = 8;
    localparam int unsigned CFG_W    = 8;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CNT_W    = 4;
    localparam int unsigned MATCH_W  = 2;

    // Settling rule
    localparam logic [VAL_W-1:0]   SETTLE_TOL     = 8'd2;
    localparam logic [MATCH_W-1:0] SETTLE_MATCHES = 2'd2;
    localparam logic [MATCH_W-1:0] MATCH_SAT      = 2'd3;
    localparam logic [VAL_W-1:0]   REMAP_VALUE    = 8'd2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_START  = 2'd0,
        ACT_SAMPLE = 2'd1,
        ACT_ENABLE = 2'd2,
        ACT_QUERY  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        KIND_MEASURED = 2'd0,
        KIND_DISABLED = 2'd1,
        KIND_QUERY    = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        MS_DISABLED = 4'd0,
        MS_UNSTABLE = 4'd1,
        MS_AIR      = 4'd2,
        MS_VERY_DRY = 4'd3,
        MS_DRY      = 4'd4,
        MS_NORMAL   = 4'd5,
        MS_WET      = 4'd6,
        MS_VERY_WET = 4'd7,
        MS_SHORT    = 4'd8
    } moist_state_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IN_AIR    = 3'd0,
        REG_VERY_DRY  = 3'd1,
        REG_DRY       = 3'd2,
        REG_NORMAL    = 3'd3,
        REG_WET       = 3'd4,
        REG_VERY_WET  = 3'd5,
        REG_MASK      = 3'd6,
        REG_UNUSED    = 3'd7
    } cfg_idx_t;

    // Work carried into the memory stage
    typedef enum logic [1:0] {
        OP_FINISH    = 2'd0,
        OP_DISABLE   = 2'd1,
        OP_QUERY     = 2'd2,
        OP_QUERY_OOR = 2'd3
    } op_t;

endpackage

### hw/rtl/smqc_in_if.sv
interface smqc_in_if
    import smqc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [ACTION_W-1:0] action;
    logic [CH_W-1:0]    channel;
    logic [RAW_W-1:0]   sample;

    modport source (output valid, output action, output channel, output sample, input ready);
    modport sink   (input valid, input action, input channel, input sample, output ready);
endinterface

### hw/rtl/smqc_out_if.sv
interface smqc_out_if
    import smqc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CH_W-1:0]  out_channel;
    logic [1:0]       kind;
    logic [VAL_W-1:0] moisture_value;
    logic [3:0]       moisture_state;
    logic             state_changed;

    modport source (output valid, output out_channel, output kind, output moisture_value,
                    output moisture_state, output state_changed, input ready);
    modport sink   (input valid, input out_channel, input kind, input moisture_value,
                    input moisture_state, input state_changed, output ready);
endinterface

### hw/rtl/soil_moisture_qualify_classify.sv
// Soil moisture qualifier and classifier.
// Requests arrive on meas (action, channel, sample); results leave on result.
// A start request opens a measurement on a channel, sample requests feed it;
// the run settles after two consecutive samples within 2 of the one before,
// or gives the unstable code after MAX_SAMPLES samples. Enable requests mark
// unconnected channels disabled, query requests read back value and state.
// Throughput: one request per cycle while the receiver does not stall. Each
// result is registered first in the memory stage, where the per-channel value
// memory is read, and then in the output register. Requests that cause no
// result simply vanish. The per-channel values live in a synchronous memory
// with one read and one write port; a read-modify-write of the same channel in
// consecutive cycles is forwarded from the write stage.
// Reset clears the measurement state, loads the default thresholds and mask,
// and clears the memory valid bits so every channel reads the unstable code.
// When the receiver stalls, one result waits in the output register and one
// more request is held in the memory stage; meas.ready then drops.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once.
module soil_moisture_qualify_classify
    import smqc_pkg::*;
#(
    parameter int unsigned CHANNELS      = 8,
    parameter int unsigned MAX_SAMPLES   = 12,
    parameter int unsigned DISABLED_CODE = 255,
    parameter int unsigned UNSTABLE_CODE = 254
) (
    input  logic                 clk,
    input  logic                 rst_n,
    smqc_in_if.sink              meas,
    smqc_out_if.source           result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int unsigned ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [VAL_W-1:0] DIS_V  = VAL_W'(DISABLED_CODE);
    localparam logic [VAL_W-1:0] UNST_V = VAL_W'(UNSTABLE_CODE);
    localparam logic [CNT_W-1:0] MAX_C  = CNT_W'(MAX_SAMPLES);

    // Configuration registers
    logic [CFG_W-1:0] lvl_air_reg, lvl_vdry_reg, lvl_dry_reg;
    logic [CFG_W-1:0] lvl_norm_reg, lvl_wet_reg, lvl_vwet_reg;
    logic [CFG_W-1:0] mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lvl_air_reg  <= 8'd240;
            lvl_vdry_reg <= 8'd200;
            lvl_dry_reg  <= 8'd160;
            lvl_norm_reg <= 8'd120;
            lvl_wet_reg  <= 8'd80;
            lvl_vwet_reg <= 8'd40;
            mask_reg     <= 8'd255;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_IN_AIR:   lvl_air_reg  <= cfg_data;
                REG_VERY_DRY: lvl_vdry_reg <= cfg_data;
                REG_DRY:      lvl_dry_reg  <= cfg_data;
                REG_NORMAL:   lvl_norm_reg <= cfg_data;
                REG_WET:      lvl_wet_reg  <= cfg_data;
                REG_VERY_WET: lvl_vwet_reg <= cfg_data;
                REG_MASK:     mask_reg     <= cfg_data;
                REG_UNUSED:   ;
            endcase
        end
    end

    function automatic moist_state_t classify(input logic [VAL_W-1:0] v);
        moist_state_t s;
        priority if (v == DIS_V)        s = MS_DISABLED;
        else if (v == UNST_V)           s = MS_UNSTABLE;
        else if (v > lvl_air_reg)       s = MS_AIR;
        else if (v > lvl_vdry_reg)      s = MS_VERY_DRY;
        else if (v > lvl_dry_reg)       s = MS_DRY;
        else if (v > lvl_norm_reg)      s = MS_NORMAL;
        else if (v > lvl_wet_reg)       s = MS_WET;
        else if (v > lvl_vwet_reg)      s = MS_VERY_WET;
        else                            s = MS_SHORT;
        return s;
    endfunction

    // Measurement run state
    logic               busy_reg, busy_next;
    logic [CH_W-1:0]    act_ch_reg, act_ch_next;
    logic [VAL_W-1:0]   prev_reg, prev_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [MATCH_W-1:0] match_reg, match_next;

    // Memory stage
    logic               s1_valid_reg;
    op_t                s1_op_reg;
    logic [CH_W-1:0]    s1_ch_reg;
    logic [VAL_W-1:0]   s1_val_reg;
    logic               s1_hit_reg;
    logic [VAL_W-1:0]   s1_fwd_reg;

    // Output register
    logic               out_valid_reg;
    logic [CH_W-1:0]    out_ch_reg;
    kind_t              out_kind_reg;
    logic [VAL_W-1:0]   out_val_reg;
    moist_state_t       out_state_reg;
    logic               out_chg_reg;

    // Channel value memory with reset valid bits
    logic [VAL_W-1:0]    mem [CHANNELS];
    logic [CHANNELS-1:0] mem_valid_reg;
    logic [VAL_W-1:0]    rd_data_reg;
    logic                rd_valid_reg;

    logic               acc, s1_adv, in_range;
    logic               s0_issue, do_sample;
    op_t                s0_op;
    logic [CH_W-1:0]    s0_ch;
    logic [VAL_W-1:0]   s0_val;
    logic [ADDR_W-1:0]  rd_addr, wr_addr;
    logic               wr_en, s1_write, res_en;
    logic [VAL_W-1:0]   wr_data;

    logic [VAL_W-1:0]   cur, diff, base_prev;
    logic [CNT_W-1:0]   base_cnt, cnt_inc;
    logic [MATCH_W-1:0] base_match, m;

    assign s1_adv     = s1_valid_reg && (!out_valid_reg || result.ready);
    assign meas.ready = !s1_valid_reg || s1_adv;
    assign acc        = meas.valid && meas.ready;
    assign in_range   = ({1'b0, meas.channel} < 4'(CHANNELS));
    assign cur        = meas.sample[RAW_W-1:2];

    // Request decode and sample qualification
    always_comb
    begin
        busy_next   = busy_reg;
        act_ch_next = act_ch_reg;
        prev_next   = prev_reg;
        cnt_next    = cnt_reg;
        match_next  = match_reg;
        s0_issue    = 1'b0;
        s0_op       = OP_QUERY;
        s0_ch       = meas.channel;
        s0_val      = cur;
        do_sample   = 1'b0;
        base_prev   = prev_reg;
        base_cnt    = cnt_reg;
        base_match  = match_reg;
        diff        = '0;
        m           = '0;
        cnt_inc     = '0;

        unique case (action_t'(meas.action))
            ACT_START:
            begin
                if (in_range)
                begin
                    do_sample   = 1'b1;
                    busy_next   = 1'b1;
                    act_ch_next = meas.channel;
                    base_prev   = '0;
                    base_cnt    = '0;
                    base_match  = '0;
                end
            end
            ACT_SAMPLE:
            begin
                do_sample = busy_reg;
            end
            ACT_ENABLE:
            begin
                if (in_range && !mask_reg[meas.channel])
                begin
                    s0_issue = 1'b1;
                    s0_op    = OP_DISABLE;
                end
            end
            ACT_QUERY:
            begin
                s0_issue = 1'b1;
                s0_op    = in_range ? OP_QUERY : OP_QUERY_OOR;
            end
        endcase

        if (do_sample)
        begin
            s0_ch   = act_ch_next;
            s0_op   = OP_FINISH;
            diff    = (cur >= base_prev) ? (cur - base_prev) : (base_prev - cur);
            cnt_inc = base_cnt + 1'b1;
            m       = base_match;
            if (diff <= SETTLE_TOL)
            begin
                if ((base_cnt != '0) && (base_match < MATCH_SAT))
                    m = base_match + 1'b1;
            end
            else
                m = '0;
            match_next = m;

            if ((diff <= SETTLE_TOL) && (m == SETTLE_MATCHES))
            begin
                // settled: reserved codes fold onto the remap value
                s0_issue  = 1'b1;
                s0_val    = ((cur == DIS_V) || (cur == UNST_V)) ? REMAP_VALUE : cur;
                busy_next = 1'b0;
                prev_next = base_prev;
                cnt_next  = base_cnt;
            end
            else
            begin
                prev_next = cur;
                cnt_next  = cnt_inc;
                if (cnt_inc >= MAX_C)
                begin
                    s0_issue  = 1'b1;
                    s0_val    = UNST_V;
                    busy_next = 1'b0;
                end
            end
        end
    end

    assign rd_addr = s0_ch[ADDR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            act_ch_reg <= '0;
            prev_reg   <= '0;
            cnt_reg    <= '0;
            match_reg  <= '0;
        end
        else if (acc)
        begin
            busy_reg   <= busy_next;
            act_ch_reg <= act_ch_next;
            prev_reg   <= prev_next;
            cnt_reg    <= cnt_next;
            match_reg  <= match_next;
        end
    end

    // Memory stage: resolve old value, forward a same-edge write
    logic [VAL_W-1:0] old_val;
    moist_state_t     old_state, new_state;

    assign old_val   = s1_hit_reg ? s1_fwd_reg : (rd_valid_reg ? rd_data_reg : UNST_V);
    assign old_state = classify(old_val);
    assign new_state = classify(s1_val_reg);

    always_comb
    begin
        res_en   = 1'b1;
        s1_write = 1'b0;
        wr_data  = s1_val_reg;
        unique case (s1_op_reg)
            OP_FINISH:    s1_write = 1'b1;
            OP_DISABLE:
            begin
                res_en   = (old_val != DIS_V);
                s1_write = res_en;
                wr_data  = DIS_V;
            end
            OP_QUERY:     ;
            OP_QUERY_OOR: ;
        endcase
    end

    assign wr_en   = s1_adv && s1_write;
    assign wr_addr = s1_ch_reg[ADDR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (meas.ready)
            s1_valid_reg <= acc && s0_issue;
    end

    always_ff @(posedge clk)
    begin
        if (acc && s0_issue)
        begin
            s1_op_reg  <= s0_op;
            s1_ch_reg  <= s0_ch;
            s1_val_reg <= s0_val;
            s1_hit_reg <= wr_en && (wr_addr == rd_addr);
            s1_fwd_reg <= wr_data;
        end
    end

    // Value memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (acc && s0_issue)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
                mem_valid_reg[wr_addr] <= 1'b1;
            if (acc && s0_issue)
                rd_valid_reg <= mem_valid_reg[rd_addr];
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_adv)
            out_valid_reg <= res_en;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_ch_reg <= s1_ch_reg;
            unique case (s1_op_reg)
                OP_FINISH:
                begin
                    out_kind_reg  <= KIND_MEASURED;
                    out_val_reg   <= s1_val_reg;
                    out_state_reg <= new_state;
                    out_chg_reg   <= (old_state != new_state);
                end
                OP_DISABLE:
                begin
                    out_kind_reg  <= KIND_DISABLED;
                    out_val_reg   <= DIS_V;
                    out_state_reg <= MS_DISABLED;
                    out_chg_reg   <= 1'b1;
                end
                OP_QUERY:
                begin
                    out_kind_reg  <= KIND_QUERY;
                    out_val_reg   <= old_val;
                    out_state_reg <= old_state;
                    out_chg_reg   <= 1'b0;
                end
                OP_QUERY_OOR:
                begin
                    out_kind_reg  <= KIND_QUERY;
                    out_val_reg   <= DIS_V;
                    out_state_reg <= MS_DISABLED;
                    out_chg_reg   <= 1'b0;
                end
            endcase
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.out_channel    = out_ch_reg;
    assign result.kind           = out_kind_reg;
    assign result.moisture_value = out_val_reg;
    assign result.moisture_state = out_state_reg;
    assign result.state_changed  = out_chg_reg;

endmodule

### tb/soil_moisture_qualify_classify_tb.sv
module soil_moisture_qualify_classify_tb;
    import smqc_pkg::*;

    localparam int unsigned CHANNELS      = 8;
    localparam int unsigned MAX_SAMPLES   = 12;
    localparam int unsigned DISABLED_CODE = 255;
    localparam int unsigned UNSTABLE_CODE = 254;

    localparam logic [VAL_W-1:0] DIS_V = VAL_W'(DISABLED_CODE);
    localparam logic [VAL_W-1:0] UNS_V = VAL_W'(UNSTABLE_CODE);

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 11;
    localparam int IDLE_PCT      = 23;
    localparam int PHASE_ITEMS   = 200;
    localparam int DRAIN_CYCLES  = 6;
    localparam int TIMEOUT_UNITS = 12 * 300000;

    typedef struct packed {
        action_t          action;
        logic [CH_W-1:0]  ch;
        logic [RAW_W-1:0] raw;
        logic             drain;
    } meas_req_t;

    typedef struct packed {
        logic [CH_W-1:0]  ch;
        kind_t            kind;
        logic [VAL_W-1:0] value;
        moist_state_t     state;
        logic             changed;
    } moist_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    smqc_in_if  meas_if();
    smqc_out_if res_if();

    soil_moisture_qualify_classify #(
        .CHANNELS      (CHANNELS),
        .MAX_SAMPLES   (MAX_SAMPLES),
        .DISABLED_CODE (DISABLED_CODE),
        .UNSTABLE_CODE (UNSTABLE_CODE)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .meas      (meas_if),
        .result    (res_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor copy of the block state and registers
    logic [VAL_W-1:0]   thr [0:5];
    logic [VAL_W-1:0]   probe_mask;
    logic [VAL_W-1:0]   stored_value [0:CHANNELS-1];
    logic               run_open;
    logic [CH_W-1:0]    run_channel;
    logic [VAL_W-1:0]   last_sample;
    logic [CNT_W-1:0]   samples_taken;
    logic [MATCH_W-1:0] settle_matches;

    meas_req_t     pending_reqs [$];
    moist_result_t expected_results [$];
    meas_req_t     driven;
    moist_result_t want;
    int            reqs_sent;
    int            results_seen;
    int            errors;
    int            reqs_made;
    logic          drain_next;

    // Clock
    initial clk = 1'b0;
    always #(CLK_HALF) clk = ~clk;

    // Threshold ladder, strict greater-than from the top down
    function automatic moist_state_t classify_moisture(logic [VAL_W-1:0] v);
        if (v == DIS_V) return MS_DISABLED;
        if (v == UNS_V) return MS_UNSTABLE;
        if (v > thr[REG_IN_AIR]) return MS_AIR;
        if (v > thr[REG_VERY_DRY]) return MS_VERY_DRY;
        if (v > thr[REG_DRY]) return MS_DRY;
        if (v > thr[REG_NORMAL]) return MS_NORMAL;
        if (v > thr[REG_WET]) return MS_WET;
        if (v > thr[REG_VERY_WET]) return MS_VERY_WET;
        return MS_SHORT;
    endfunction

    function automatic void push_result(logic [CH_W-1:0] ch, kind_t kind,
                                        logic [VAL_W-1:0] value, moist_state_t state,
                                        logic changed);
        moist_result_t r;
        r.ch      = ch;
        r.kind    = kind;
        r.value   = value;
        r.state   = state;
        r.changed = changed;
        expected_results.push_back(r);
    endfunction

    function automatic void close_run(logic [VAL_W-1:0] v);
        moist_state_t old_s;
        moist_state_t new_s;
        old_s = classify_moisture(stored_value[run_channel]);
        new_s = classify_moisture(v);
        stored_value[run_channel] = v;
        run_open = 1'b0;
        push_result(run_channel, KIND_MEASURED, v, new_s, old_s != new_s);
    endfunction

    function automatic void take_sample(logic [RAW_W-1:0] raw);
        logic [VAL_W-1:0] cur;
        logic [VAL_W-1:0] diff;
        cur  = raw[RAW_W-1:2];
        diff = (cur >= last_sample) ? cur - last_sample : last_sample - cur;
        if (diff <= SETTLE_TOL)
        begin
            // first sample of a run never counts as a match
            if (samples_taken != 0 && settle_matches < MATCH_SAT)
                settle_matches = settle_matches + 1'b1;
            if (settle_matches == SETTLE_MATCHES)
            begin
                if (cur == DIS_V || cur == UNS_V)
                    cur = REMAP_VALUE;
                close_run(cur);
                return;
            end
        end
        else
        begin
            settle_matches = '0;
        end
        last_sample   = cur;
        samples_taken = samples_taken + 1'b1;
        if (samples_taken >= MAX_SAMPLES)
            close_run(UNS_V);
    endfunction

    function automatic void predict_request(meas_req_t r);
        moist_state_t old_s;
        logic         in_range;
        in_range = (r.ch < CHANNELS);
        case (r.action)
            ACT_START:
            begin
                if (in_range)
                begin
                    run_open       = 1'b1;
                    run_channel    = r.ch;
                    last_sample    = '0;
                    samples_taken  = '0;
                    settle_matches = '0;
                    take_sample(r.raw);
                end
            end
            ACT_SAMPLE:
            begin
                if (run_open)
                    take_sample(r.raw);
            end
            ACT_ENABLE:
            begin
                if (in_range && !probe_mask[r.ch] && stored_value[r.ch] != DIS_V)
                begin
                    old_s = classify_moisture(stored_value[r.ch]);
                    stored_value[r.ch] = DIS_V;
                    push_result(r.ch, KIND_DISABLED, DIS_V, MS_DISABLED,
                                old_s != MS_DISABLED);
                end
            end
            default:
            begin
                if (!in_range)
                    push_result(r.ch, KIND_QUERY, DIS_V, MS_DISABLED, 1'b0);
                else
                    push_result(r.ch, KIND_QUERY, stored_value[r.ch],
                                classify_moisture(stored_value[r.ch]), 1'b0);
            end
        endcase
    endfunction

    // Request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meas_if.valid <= 1'b0;
        end
        else
        begin
            if (meas_if.valid && meas_if.ready)
            begin
                predict_request(driven);
                reqs_sent = reqs_sent + 1;
            end
            if (!meas_if.valid || meas_if.ready)
            begin
                if (pending_reqs.size() != 0
                    && !(pending_reqs[0].drain && expected_results.size() != 0)
                    && ((reqs_sent >= 700 && reqs_sent < 1000)
                        || $urandom_range(99) >= IDLE_PCT))
                begin
                    driven = pending_reqs.pop_front();
                    meas_if.valid   <= 1'b1;
                    meas_if.action  <= driven.action;
                    meas_if.channel <= driven.ch;
                    meas_if.sample  <= driven.raw;
                end
                else
                begin
                    meas_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
        end
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with none expected: channel %0d kind %0d",
                           res_if.out_channel, res_if.kind);
                    errors = errors + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (res_if.out_channel !== want.ch)
                    begin
                        $error("out_channel: expected %0d, got %0d", want.ch,
                               res_if.out_channel);
                        errors = errors + 1;
                    end
                    if (res_if.kind !== want.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want.kind, res_if.kind);
                        errors = errors + 1;
                    end
                    if (res_if.moisture_value !== want.value)
                    begin
                        $error("moisture_value: expected %0d, got %0d", want.value,
                               res_if.moisture_value);
                        errors = errors + 1;
                    end
                    if (res_if.moisture_state !== want.state)
                    begin
                        $error("moisture_state: expected %0d, got %0d", want.state,
                               res_if.moisture_state);
                        errors = errors + 1;
                    end
                    if (res_if.state_changed !== want.changed)
                    begin
                        $error("state_changed: expected %0d, got %0d", want.changed,
                               res_if.state_changed);
                        errors = errors + 1;
                    end
                end
                results_seen = results_seen + 1;
            end
            res_if.ready <= (results_seen >= 250 && results_seen < 400)
                            || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Stimulus helpers
    function automatic void push_req(action_t a, logic [CH_W-1:0] ch, logic [RAW_W-1:0] raw);
        meas_req_t r;
        r.action = a;
        r.ch     = ch;
        r.raw    = raw;
        r.drain  = drain_next;
        drain_next = 1'b0;
        pending_reqs.push_back(r);
        reqs_made = reqs_made + 1;
    endfunction

    function automatic logic [RAW_W-1:0] raw_of(logic [VAL_W-1:0] v);
        logic [1:0] lsb;
        lsb = 2'($urandom_range(3));
        return {v, lsb};
    endfunction

    // Values biased toward the reserved codes and the threshold edges
    function automatic logic [VAL_W-1:0] pick_level();
        int unsigned r;
        logic [VAL_W-1:0] v;
        r = $urandom_range(99);
        if (r < 30)
            v = 8'($urandom_range(255));
        else if (r < 50)
        begin
            case ($urandom_range(5))
                0: v = 8'd0;
                1: v = 8'd1;
                2: v = 8'd2;
                3: v = 8'd253;
                4: v = UNS_V;
                default: v = DIS_V;
            endcase
        end
        else
            v = thr[$urandom_range(5)] + 8'($urandom_range(2)) - 8'd1;
        return v;
    endfunction

    function automatic logic [VAL_W-1:0] jitter(logic [VAL_W-1:0] v);
        int t;
        t = int'(v) + int'($urandom_range(4)) - 2;
        if (t < 0) t = 0;
        if (t > 255) t = 255;
        return t[VAL_W-1:0];
    endfunction

    function automatic logic [VAL_W-1:0] jump(logic [VAL_W-1:0] v);
        logic [VAL_W-1:0] d;
        d = 8'($urandom_range(3, 127));
        return ($urandom_range(1) != 0) ? v + d : v - d;
    endfunction

    // One measurement run; mode picks settle, late settle, unstable, wander, abandon
    function automatic void gen_measurement(logic [CH_W-1:0] ch, int mode);
        logic [VAL_W-1:0] v;
        int n_jump;
        int n_jit;
        int i;
        v = pick_level();
        push_req(ACT_START, ch, raw_of(v));
        n_jump = 0;
        n_jit  = 2;
        case (mode)
            1: n_jump = $urandom_range(1, 8);
            2:
            begin
                n_jump = MAX_SAMPLES - 1;
                n_jit  = 0;
            end
            3:
            begin
                n_jit = $urandom_range(2, 11);
                for (i = 0; i < n_jit; i++)
                begin
                    v = ($urandom_range(2) == 0) ? jump(v) : jitter(v);
                    push_req(ACT_SAMPLE, ch, raw_of(v));
                end
                n_jit = 0;
            end
            4: n_jit = $urandom_range(0, 1);
            default: ;
        endcase
        for (i = 0; i < n_jump; i++)
        begin
            v = jump(v);
            push_req(ACT_SAMPLE, 3'($urandom_range(7)), raw_of(v));
        end
        for (i = 0; i < n_jit; i++)
        begin
            v = jitter(v);
            push_req(ACT_SAMPLE, 3'($urandom_range(7)), raw_of(v));
        end
    endfunction

    task automatic run_random(int target);
        int start_cnt;
        int r;
        int m;
        logic drained;
        start_cnt = reqs_made;
        drained   = 1'b0;
        while (reqs_made - start_cnt < target)
        begin
            // hold the sender once per phase until all results are back
            if (!drained && reqs_made - start_cnt >= target / 2)
            begin
                drain_next = 1'b1;
                drained    = 1'b1;
            end
            r = $urandom_range(99);
            if (r < 52)
            begin
                m = $urandom_range(99);
                gen_measurement(3'($urandom_range(7)),
                                m < 35 ? 0 : m < 60 ? 1 : m < 70 ? 2 : m < 90 ? 3 : 4);
            end
            else if (r < 67)
                push_req(ACT_QUERY, 3'($urandom_range(7)), 10'($urandom_range(1023)));
            else if (r < 80)
                push_req(ACT_ENABLE, 3'($urandom_range(7)), 10'($urandom_range(1023)));
            else if (r < 87)
                push_req(ACT_SAMPLE, 3'($urandom_range(7)), 10'($urandom_range(1023)));
            else
            begin
                // restart on top of an open run
                push_req(ACT_START, 3'($urandom_range(7)), 10'($urandom_range(1023)));
                gen_measurement(3'($urandom_range(7)), 0);
            end
        end
    endtask

    task automatic run_directed();
        int i;
        push_req(ACT_QUERY, 3'd0, 10'd0);
        // sample with no run open
        push_req(ACT_SAMPLE, 3'd5, 10'h3FF);
        // full scale settles on the disabled code, remapped
        push_req(ACT_START, 3'd7, 10'h3FF);
        push_req(ACT_SAMPLE, 3'd0, 10'h3FE);
        push_req(ACT_SAMPLE, 3'd0, 10'h3FD);
        // zero input
        push_req(ACT_START, 3'd0, 10'h000);
        push_req(ACT_SAMPLE, 3'd0, 10'h000);
        push_req(ACT_SAMPLE, 3'd0, 10'h001);
        // settles on the unstable code, remapped
        push_req(ACT_START, 3'd1, {UNS_V, 2'b00});
        push_req(ACT_SAMPLE, 3'd1, {UNS_V, 2'b11});
        push_req(ACT_SAMPLE, 3'd1, {UNS_V, 2'b01});
        // never settles
        for (i = 0; i < MAX_SAMPLES; i++)
            push_req(i == 0 ? ACT_START : ACT_SAMPLE, 3'd2, i[0] ? 10'h3FF : 10'h000);
        // start while busy drops the open run
        push_req(ACT_START, 3'd3, 10'd600);
        push_req(ACT_START, 3'd3, {8'd200, 2'b00});
        push_req(ACT_SAMPLE, 3'd3, {8'd201, 2'b00});
        push_req(ACT_SAMPLE, 3'd3, {8'd200, 2'b10});
        // enable on a connected channel
        push_req(ACT_ENABLE, 3'd4, 10'd0);
        push_req(ACT_QUERY, 3'd2, 10'd0);
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || meas_if.valid || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(cfg_idx_t idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_MASK:   probe_mask = val;
            REG_UNUSED: ;
            default:    thr[idx] = val;
        endcase
    endtask

    // Main sequence
    initial
    begin : main_seq
        logic [VAL_W-1:0] lv [0:5];
        logic [VAL_W-1:0] m;
        int p;
        int k;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = REG_IN_AIR;
        cfg_data        = '0;
        meas_if.valid   = 1'b0;
        meas_if.action  = ACT_START;
        meas_if.channel = '0;
        meas_if.sample  = '0;
        res_if.ready    = 1'b0;
        reqs_sent       = 0;
        results_seen    = 0;
        errors          = 0;
        reqs_made       = 0;
        drain_next      = 1'b0;
        thr[REG_IN_AIR]   = 8'd240;
        thr[REG_VERY_DRY] = 8'd200;
        thr[REG_DRY]      = 8'd160;
        thr[REG_NORMAL]   = 8'd120;
        thr[REG_WET]      = 8'd80;
        thr[REG_VERY_WET] = 8'd40;
        probe_mask        = 8'hFF;
        for (k = 0; k < CHANNELS; k++)
            stored_value[k] = UNS_V;
        run_open       = 1'b0;
        run_channel    = '0;
        last_sample    = '0;
        samples_taken  = '0;
        settle_matches = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings first
        run_directed();
        run_random(PHASE_ITEMS - 30);
        wait_idle();

        for (p = 1; p < 8; p++)
        begin
            case (p)
                1:
                begin
                    lv = '{8'd240, 8'd200, 8'd160, 8'd120, 8'd80, 8'd40};
                    m  = 8'h00;
                end
                2:
                begin
                    lv = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
                    m  = 8'($urandom_range(255));
                end
                3:
                begin
                    lv = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
                    m  = 8'hFF;
                end
                5, 6:
                begin
                    for (k = 0; k < 6; k++)
                        lv[k] = 8'($urandom_range(255));
                    m = (p == 6) ? 8'h55 : 8'($urandom_range(255));
                end
                default:
                begin
                    // random descending ladder
                    lv[0] = 8'($urandom_range(150, 255));
                    for (k = 1; k < 6; k++)
                        lv[k] = lv[k-1] - 8'($urandom_range(lv[k-1] / 3));
                    m = (p == 7) ? 8'hFF : 8'($urandom_range(255));
                end
            endcase
            for (k = 0; k < 6; k++)
                write_cfg(cfg_idx_t'(k), lv[k]);
            write_cfg(REG_MASK, m);
            if (p == 1)
                write_cfg(REG_UNUSED, 8'hA5);
            run_random(PHASE_ITEMS);
            wait_idle();
        end

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(TIMEOUT_UNITS);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

### files.f
hw/rtl/smqc_pkg.sv
hw/rtl/smqc_in_if.sv
hw/rtl/smqc_out_if.sv
hw/rtl/soil_moisture_qualify_classify.sv
tb/soil_moisture_qualify_classify_tb.sv
